/* hdl/tgpb_pkg.sv */
`default_nettype none

package tgpb_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DEPTH_MODE      = 2'd0;
    localparam logic [1:0] REG_TRANSPARENT_KEY = 2'd1;
    localparam logic [1:0] REG_TINT_COLOUR     = 2'd2;

    // Destination depth codes.
    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_32 = 2'd2;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // One quotient bit is resolved in each cell of the divider chain.
    localparam int QUO_BITS  = 8;
    localparam int NUM_CHANS = 3;

    // Per-pixel values that ride alongside the divider lanes.
    typedef struct packed {
        logic        blend;
        logic        we;
        logic [31:0] pixel;
        logic [7:0]  fa;
    } side_t;

    // Tint term: (sa * tint) / fa.
    typedef struct packed {
        logic [15:0] rem;
        logic [14:0] den;
        logic [7:0]  quo;
    } lane_a_t;

    // Destination term: (da * d * (255 - sa)) / (255 * fa), with an overflow
    // flag for quotients of 256 and above.
    typedef struct packed {
        logic [23:0] rem;
        logic [22:0] den;
        logic [7:0]  quo;
        logic        ovf;
    } lane_b_t;

    typedef struct packed {
        side_t                       side;
        lane_a_t [NUM_CHANS-1:0]     la;
        lane_b_t [NUM_CHANS-1:0]     lb;
    } cell_data_t;

endpackage

`default_nettype wire

/* hdl/tgpb_front.sv */
`default_nettype none

module tgpb_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        src_pixel,
    input  wire logic [31:0]        dest_pixel,
    input  wire logic [1:0]         depth_mode,
    input  wire logic [15:0]        transparent_key,
    input  wire logic [23:0]        tint_colour,
    output logic                    down_valid,
    output tgpb_pkg::cell_data_t    down_data,
    input  wire logic               down_ready
);
    import tgpb_pkg::*;

    // Stage 1: mode decision and the first products.
    logic                            s1_valid_reg;
    side_t                           s1_side_reg, s1_side_next;
    logic [7:0]                      s1_msa_reg, s1_msa_next;
    logic [15:0]                     s1_pa_reg, s1_pa_next;
    logic [NUM_CHANS-1:0][15:0]      s1_na_reg, s1_na_next;
    logic [NUM_CHANS-1:0][15:0]      s1_dd_reg, s1_dd_next;

    // Stage 2: result alpha, scaled divisor and the destination numerators.
    logic                            s2_valid_reg;
    side_t                           s2_side_reg, s2_side_next;
    logic [15:0]                     s2_den_reg, s2_den_next;
    logic [NUM_CHANS-1:0][15:0]      s2_na_reg;
    logic [NUM_CHANS-1:0][23:0]      s2_nb_reg, s2_nb_next;

    // Stage 3: overflow check and divider lane setup.
    logic                            s3_valid_reg;
    cell_data_t                      s3_data_reg, s3_data_next;

    logic s1_ready, s2_ready, s3_ready;
    logic [7:0] sa, da;
    logic [15:0] pa_sum;
    logic [7:0] pa_div;

    assign s3_ready = !s3_valid_reg || down_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign down_valid = s3_valid_reg;
    assign down_data  = s3_data_reg;

    assign sa = src_pixel[31:24];
    assign da = dest_pixel[31:24];

    always_comb
    begin
        s1_side_next.blend = 1'b0;
        s1_side_next.we    = 1'b0;
        s1_side_next.pixel = dest_pixel;
        s1_side_next.fa    = 8'd0;
        case (depth_mode)
            DEPTH_8:
            begin
                if ({8'd0, src_pixel[7:0]} != transparent_key)
                begin
                    s1_side_next.we    = 1'b1;
                    s1_side_next.pixel = {24'd0, src_pixel[7:0]};
                end
            end
            DEPTH_16:
            begin
                if (src_pixel[15:0] != transparent_key)
                begin
                    s1_side_next.we    = 1'b1;
                    s1_side_next.pixel = {16'd0, src_pixel[15:0]};
                end
            end
            DEPTH_32:
            begin
                if (sa != 8'd0)
                begin
                    s1_side_next.blend = 1'b1;
                    s1_side_next.we    = 1'b1;
                end
            end
            default:
            begin
                s1_side_next.we = 1'b0;
            end
        endcase

        s1_msa_next = CHAN_MAX - sa;
        s1_pa_next  = {8'd0, s1_msa_next} * {8'd0, CHAN_MAX - da};
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            s1_na_next[c] = {8'd0, sa} * {8'd0, tint_colour[c*8 +: 8]};
            s1_dd_next[c] = {8'd0, da} * {8'd0, dest_pixel[c*8 +: 8]};
        end
    end

    // Exact floor(x / 255) for x up to 255 * 255.
    assign pa_sum = s1_pa_reg + 16'd1 + {8'd0, s1_pa_reg[15:8]};
    assign pa_div = pa_sum[15:8];

    always_comb
    begin
        s2_side_next    = s1_side_reg;
        s2_side_next.fa = CHAN_MAX - pa_div;
        s2_den_next     = {s2_side_next.fa, 8'd0} - {8'd0, s2_side_next.fa};
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            s2_nb_next[c] = {8'd0, s1_dd_reg[c]} * {16'd0, s1_msa_reg};
        end
    end

    always_comb
    begin
        s3_data_next.side = s2_side_reg;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            s3_data_next.la[c].rem = s2_na_reg[c];
            s3_data_next.la[c].den = {s2_side_reg.fa, 7'd0};
            s3_data_next.la[c].quo = 8'd0;
            s3_data_next.lb[c].rem = s2_nb_reg[c];
            s3_data_next.lb[c].den = {s2_den_reg, 7'd0};
            s3_data_next.lb[c].quo = 8'd0;
            s3_data_next.lb[c].ovf = (s2_nb_reg[c][23:8] >= s2_den_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_side_reg <= s1_side_next;
            s1_msa_reg  <= s1_msa_next;
            s1_pa_reg   <= s1_pa_next;
            s1_na_reg   <= s1_na_next;
            s1_dd_reg   <= s1_dd_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_side_reg <= s2_side_next;
            s2_den_reg  <= s2_den_next;
            s2_na_reg   <= s1_na_reg;
            s2_nb_reg   <= s2_nb_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/tgpb_div_cell.sv */
`default_nettype none

module tgpb_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire tgpb_pkg::cell_data_t up_data,
    output logic                    down_valid,
    input  wire logic               down_ready,
    output tgpb_pkg::cell_data_t    down_data
);
    import tgpb_pkg::*;

    logic       valid_reg;
    cell_data_t data_reg, data_next;
    logic       ge_a, ge_b;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // One restoring step per lane: the divisor arrives pre-shifted and is
    // halved for the next cell.
    always_comb
    begin
        data_next = up_data;
        ge_a = 1'b0;
        ge_b = 1'b0;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            ge_a = (up_data.la[c].rem >= {1'b0, up_data.la[c].den});
            if (ge_a)
            begin
                data_next.la[c].rem = up_data.la[c].rem - {1'b0, up_data.la[c].den};
            end
            data_next.la[c].quo = {up_data.la[c].quo[6:0], ge_a};
            data_next.la[c].den = up_data.la[c].den >> 1;

            ge_b = (up_data.lb[c].rem >= {1'b0, up_data.lb[c].den});
            if (ge_b)
            begin
                data_next.lb[c].rem = up_data.lb[c].rem - {1'b0, up_data.lb[c].den};
            end
            data_next.lb[c].quo = {up_data.lb[c].quo[6:0], ge_b};
            data_next.lb[c].den = up_data.lb[c].den >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/tgpb_out.sv */
`default_nettype none

module tgpb_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire tgpb_pkg::cell_data_t up_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             out_pixel,
    output logic                    write_enable
);
    import tgpb_pkg::*;

    logic        valid_reg;
    logic [31:0] pixel_reg, pixel_next;
    logic        we_reg, we_next;
    logic [8:0]  sum;

    assign up_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_pixel    = pixel_reg;
    assign write_enable = we_reg;

    // In blend mode add the two quotients per channel and clamp at full scale.
    always_comb
    begin
        sum        = 9'd0;
        pixel_next = up_data.side.pixel;
        we_next    = up_data.side.we;
        if (up_data.side.blend)
        begin
            pixel_next[31:24] = up_data.side.fa;
            for (int c = 0; c < NUM_CHANS; c++)
            begin
                sum = {1'b0, up_data.la[c].quo} + {1'b0, up_data.lb[c].quo};
                if (up_data.lb[c].ovf || sum[8])
                begin
                    pixel_next[c*8 +: 8] = CHAN_MAX;
                end
                else
                begin
                    pixel_next[c*8 +: 8] = sum[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            pixel_reg <= pixel_next;
            we_reg    <= we_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/tinted_glyph_pixel_blend.sv */
`default_nettype none

// Channel   Handshake               Payload
// config    cfg_write               cfg_index[1:0], cfg_data[23:0]
// input     in_valid / in_ready     src_pixel[31:0], dest_pixel[31:0]
// output    out_valid / out_ready   out_pixel[31:0], write_enable
//
// One pixel transfer is accepted per cycle while in_ready is high. Each result
// passes through three setup stages, eight divider cells (one quotient bit
// each) and the output register.
// Reset is asynchronous, clears all valid flags and returns the configuration
// to its reset values (32-bit depth, key zero, white tint).
// Every stage holds its own valid flag, so a stalled output only backs up
// the pipeline once all stages are full.

module tinted_glyph_pixel_blend (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] src_pixel,
    input  wire logic [31:0] dest_pixel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_pixel,
    output logic             write_enable
);
    import tgpb_pkg::*;

    logic [1:0]  depth_mode_reg;
    logic [15:0] transparent_key_reg;
    logic [23:0] tint_colour_reg;

    // Register file. Writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg      <= DEPTH_32;
            transparent_key_reg <= 16'd0;
            tint_colour_reg     <= 24'hFFFFFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEPTH_MODE:      depth_mode_reg      <= cfg_data[1:0];
                REG_TRANSPARENT_KEY: transparent_key_reg <= cfg_data[15:0];
                REG_TINT_COLOUR:     tint_colour_reg     <= cfg_data;
                default:             depth_mode_reg      <= depth_mode_reg;
            endcase
        end
    end

    // Pipeline links: link 0 leaves the setup stages, link QUO_BITS enters
    // the output register.
    logic       link_valid [QUO_BITS+1];
    logic       link_ready [QUO_BITS+1];
    cell_data_t link_data  [QUO_BITS+1];

    // Setup stages: color-key decision for the narrow modes, the products,
    // the result alpha and the aligned divisors for the 32-bit blend.
    tgpb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .src_pixel       (src_pixel),
        .dest_pixel      (dest_pixel),
        .depth_mode      (depth_mode_reg),
        .transparent_key (transparent_key_reg),
        .tint_colour     (tint_colour_reg),
        .down_valid      (link_valid[0]),
        .down_data       (link_data[0]),
        .down_ready      (link_ready[0])
    );

    // The divider chain. Each cell resolves one quotient bit of all six
    // divisions and hands the partial remainders to its neighbor.
    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        tgpb_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[i]),
            .up_ready   (link_ready[i]),
            .up_data    (link_data[i]),
            .down_valid (link_valid[i+1]),
            .down_ready (link_ready[i+1]),
            .down_data  (link_data[i+1])
        );
    end

    // Channel sum, saturation and final packing into the output register.
    tgpb_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (link_valid[QUO_BITS]),
        .up_ready     (link_ready[QUO_BITS]),
        .up_data      (link_data[QUO_BITS]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_pixel    (out_pixel),
        .write_enable (write_enable)
    );

endmodule

`default_nettype wire
